@@ rtl/ogbmc_pkg.sv @@
`timescale 1ns / 1ps

package ogbmc_pkg;

    // default grid limits
    localparam int unsigned C_MAX_X = 64;
    localparam int unsigned C_MAX_Y = 64;
    localparam int unsigned C_MAX_Z = 4;

    // register reset values
    localparam logic [6:0] C_GRID_X_RST = 7'd64;
    localparam logic [6:0] C_GRID_Y_RST = 7'd64;
    localparam logic [2:0] C_GRID_Z_RST = 3'd4;

    // register indexes
    localparam logic [1:0] REG_GRID_X = 2'd0;
    localparam logic [1:0] REG_GRID_Y = 2'd1;
    localparam logic [1:0] REG_GRID_Z = 2'd2;

    // opcodes
    localparam logic [1:0] OP_MARK  = 2'd0;
    localparam logic [1:0] OP_CHECK = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // signed width for box bound arithmetic, covers anchors, extents and limits up to 256
    localparam int unsigned C_SW = 11;

    typedef struct packed {
        logic outside;    // some cell of the box lies off the grid
        logic run;        // clipped box holds at least one cell
        logic empty_ext;  // some extent is zero
    } t_box_flags;

    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } t_mem_ctl;

    // saturate a size register to the grid limit
    function automatic logic [C_SW-1:0] clip_size(input logic [C_SW-1:0] r,
                                                  input logic [C_SW-1:0] m);
        clip_size = (r > m) ? m : r;
    endfunction

endpackage

@@ rtl/ogbmc_box_setup.sv @@
`timescale 1ns / 1ps

module ogbmc_box_setup #(
    parameter int unsigned MAX_X = ogbmc_pkg::C_MAX_X,
    parameter int unsigned MAX_Y = ogbmc_pkg::C_MAX_Y,
    parameter int unsigned MAX_Z = ogbmc_pkg::C_MAX_Z,
    localparam int unsigned XW   = $clog2(MAX_X + 1)
) (
    input  logic [6:0]                   i_grid_x,
    input  logic [6:0]                   i_grid_y,
    input  logic [2:0]                   i_grid_z,
    input  logic signed [7:0]            i_anchor_x,
    input  logic signed [7:0]            i_anchor_y,
    input  logic signed [3:0]            i_anchor_z,
    input  logic [6:0]                   i_extent_x,
    input  logic [6:0]                   i_extent_y,
    input  logic [2:0]                   i_extent_z,
    output ogbmc_pkg::t_box_flags        o_flags,
    output logic [XW-1:0]                o_x_lo,
    output logic [XW-1:0]                o_x_hi,
    output logic [MAX_Y*MAX_Z-1:0]       o_mask
);

    localparam int unsigned SW = ogbmc_pkg::C_SW;

    logic signed [SW-1:0] gx, gy, gz;
    logic signed [SW-1:0] ax, ay, az;
    logic signed [SW-1:0] x_end, y_end, z_end;
    logic signed [SW-1:0] x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
    logic [MAX_Y-1:0]     y_sel;
    logic [MAX_Z-1:0]     z_sel;

    always_comb begin
        gx = $signed(ogbmc_pkg::clip_size({4'b0, i_grid_x}, SW'(MAX_X)));
        gy = $signed(ogbmc_pkg::clip_size({4'b0, i_grid_y}, SW'(MAX_Y)));
        gz = $signed(ogbmc_pkg::clip_size({8'b0, i_grid_z}, SW'(MAX_Z)));

        ax = SW'(i_anchor_x);
        ay = SW'(i_anchor_y);
        az = SW'(i_anchor_z);

        x_end = ax + $signed({4'b0, i_extent_x});
        y_end = ay + $signed({4'b0, i_extent_y});
        z_end = az + $signed({8'b0, i_extent_z});

        // clipped half-open range on each axis
        x_lo = (ax < 0) ? '0 : ax;
        y_lo = (ay < 0) ? '0 : ay;
        z_lo = (az < 0) ? '0 : az;
        x_hi = (x_end > gx) ? gx : x_end;
        y_hi = (y_end > gy) ? gy : y_end;
        z_hi = (z_end > gz) ? gz : z_end;

        o_flags.outside   = (ax < 0) || (ay < 0) || (az < 0) ||
                            (x_end > gx) || (y_end > gy) || (z_end > gz);
        o_flags.run       = (x_lo < x_hi) && (y_lo < y_hi) && (z_lo < z_hi);
        o_flags.empty_ext = (i_extent_x == '0) || (i_extent_y == '0) ||
                            (i_extent_z == '0);

        // only meaningful when run is set, then both lie within 0..MAX_X
        o_x_lo = x_lo[XW-1:0];
        o_x_hi = x_hi[XW-1:0];

        for (int y = 0; y < MAX_Y; y++) begin
            y_sel[y] = (y_lo <= $signed(SW'(y))) && ($signed(SW'(y)) < y_hi);
        end
        for (int z = 0; z < MAX_Z; z++) begin
            z_sel[z] = (z_lo <= $signed(SW'(z))) && ($signed(SW'(z)) < z_hi);
        end
        // row word bit order matches y major, z minor
        for (int y = 0; y < MAX_Y; y++) begin
            for (int z = 0; z < MAX_Z; z++) begin
                o_mask[y*MAX_Z + z] = y_sel[y] & z_sel[z];
            end
        end
    end

endmodule

@@ rtl/ogbmc_row_mem.sv @@
`timescale 1ns / 1ps

module ogbmc_row_mem #(
    parameter int unsigned MAX_X = ogbmc_pkg::C_MAX_X,
    parameter int unsigned MAX_Y = ogbmc_pkg::C_MAX_Y,
    parameter int unsigned MAX_Z = ogbmc_pkg::C_MAX_Z,
    localparam int unsigned XA   = (MAX_X > 1) ? $clog2(MAX_X) : 1,
    localparam int unsigned RW   = MAX_Y * MAX_Z
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ogbmc_pkg::t_mem_ctl   i_ctl,
    input  logic [XA-1:0]         i_raddr,
    input  logic [XA-1:0]         i_waddr,
    input  logic [RW-1:0]         i_wdata,
    output logic [RW-1:0]         o_rdata
);

    logic [RW-1:0]    r_mem [MAX_X];
    logic [MAX_X-1:0] r_row_vld;
    logic [RW-1:0]    r_rdata;
    logic             r_rd_vld_bit;

    // row contents, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // one valid bit per row, a row never written reads as free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld    <= '0;
            r_rd_vld_bit <= 1'b0;
        end else begin
            if (i_ctl.clr) begin
                r_row_vld <= '0;
            end else if (i_ctl.wr) begin
                r_row_vld[i_waddr] <= 1'b1;
            end
            if (i_ctl.rd) begin
                r_rd_vld_bit <= r_row_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_vld_bit ? r_rdata : '0;

endmodule

@@ rtl/occupancy_grid_box_mark_check.sv @@
`timescale 1ns / 1ps

// Occupancy grid with box mark and box check. The grid is a bitmap of
// MAX_X rows, one row per x cell holding MAX_Y*MAX_Z bits (y major, z minor),
// in a memory with a registered read. A mark or check walks the clipped
// x range of its box, one row read per cycle, and a mark writes each row
// back in the cycle after its read. A request is taken only in the idle
// state, so the next transaction waits until the previous one has finished;
// the single read port of the row memory sets the pace of the walk. Requests
// that touch no row (clear, out-of-bounds check, empty box, unused opcode)
// go from idle straight to the done state. A finished request waits as
// long as the previous result is not taken. Clear and reset drop the
// per-row valid bits at once, so there is no clearing pass. A new
// transaction is taken while the previous result still waits on the master
// side. Grid size registers are to be written by the user only while the
// block is idle; the block itself does not enforce this.
module occupancy_grid_box_mark_check #(
    parameter int unsigned MAX_X = ogbmc_pkg::C_MAX_X,
    parameter int unsigned MAX_Y = ogbmc_pkg::C_MAX_Y,
    parameter int unsigned MAX_Z = ogbmc_pkg::C_MAX_Z
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [6:0]  i_cfg_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[1:0], anchor_x[9:2], anchor_y[17:10], anchor_z[21:18],
    // extent_x[28:22], extent_y[35:29], extent_z[38:36], zero[39]
    input  logic [39:0] s_axis_tdata,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // box_free[0], out_of_bounds[1], zero[7:2]
    output logic [7:0]  m_axis_tdata
);

    localparam int unsigned XW = $clog2(MAX_X + 1);
    localparam int unsigned XA = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int unsigned RW = MAX_Y * MAX_Z;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // grid size registers
    logic [6:0] r_grid_x, r_grid_y;
    logic [2:0] r_grid_z;

    // request context
    logic [1:0]    r_state, n_state;
    logic [1:0]    r_op;
    logic          r_outside;
    logic          r_oob;
    logic [XW-1:0] r_x, r_x_hi;
    logic [RW-1:0] r_mask;
    logic          r_rd_vld;
    logic [XA-1:0] r_rd_x;
    logic          r_hit;

    // result register
    logic r_out_vld, r_out_free, r_out_oob;

    ogbmc_pkg::t_box_flags box_flags;
    logic [XW-1:0]         box_x_lo, box_x_hi;
    logic [RW-1:0]         box_mask;
    ogbmc_pkg::t_mem_ctl   mem_ctl;
    logic [RW-1:0]         mem_rdata;
    logic                  in_acc;
    logic                  rows_left;
    logic                  out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign rows_left     = (r_x < r_x_hi);
    assign out_free      = !r_out_vld || m_axis_tready;

    ogbmc_box_setup #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z)
    ) u_box_setup (
        .i_grid_x   (r_grid_x),
        .i_grid_y   (r_grid_y),
        .i_grid_z   (r_grid_z),
        .i_anchor_x (s_axis_tdata[9:2]),
        .i_anchor_y (s_axis_tdata[17:10]),
        .i_anchor_z (s_axis_tdata[21:18]),
        .i_extent_x (s_axis_tdata[28:22]),
        .i_extent_y (s_axis_tdata[35:29]),
        .i_extent_z (s_axis_tdata[38:36]),
        .o_flags    (box_flags),
        .o_x_lo     (box_x_lo),
        .o_x_hi     (box_x_hi),
        .o_mask     (box_mask)
    );

    // read the next row each walk cycle while rows remain, on a mark write back the row read in the previous cycle
    always_comb begin
        mem_ctl.rd  = (r_state == S_WALK) && rows_left;
        mem_ctl.wr  = r_rd_vld && (r_op == ogbmc_pkg::OP_MARK);
        mem_ctl.clr = in_acc && (s_axis_tdata[1:0] == ogbmc_pkg::OP_CLEAR);
    end

    ogbmc_row_mem #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y),
        .MAX_Z (MAX_Z)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mem_ctl),
        .i_raddr (r_x[XA-1:0]),
        .i_waddr (r_rd_x),
        .i_wdata (mem_rdata | r_mask),
        .o_rdata (mem_rdata)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    // only a mark with some cell inside the grid, or a check lying wholly inside it, walks rows
                    if (((s_axis_tdata[1:0] == ogbmc_pkg::OP_MARK) ||
                         ((s_axis_tdata[1:0] == ogbmc_pkg::OP_CHECK) &&
                          !box_flags.outside)) && box_flags.run) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_WALK: begin
                if (!rows_left && !r_rd_vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_grid_x  <= ogbmc_pkg::C_GRID_X_RST;
            r_grid_y  <= ogbmc_pkg::C_GRID_Y_RST;
            r_grid_z  <= ogbmc_pkg::C_GRID_Z_RST;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= mem_ctl.rd;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ogbmc_pkg::REG_GRID_X: r_grid_x <= i_cfg_data;
                    ogbmc_pkg::REG_GRID_Y: r_grid_y <= i_cfg_data;
                    ogbmc_pkg::REG_GRID_Z: r_grid_z <= i_cfg_data[2:0];
                    default: ;
                endcase
            end

            // result leaves when taken, a finished request refills it
            if ((r_state == S_DONE) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload and walk registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op      <= s_axis_tdata[1:0];
            r_outside <= box_flags.outside;
            r_oob     <= box_flags.outside &&
                         (((s_axis_tdata[1:0] == ogbmc_pkg::OP_MARK) &&
                           !box_flags.empty_ext) ||
                          (s_axis_tdata[1:0] == ogbmc_pkg::OP_CHECK));
            r_x       <= box_x_lo;
            r_x_hi    <= box_x_hi;
            r_mask    <= box_mask;
            r_hit     <= 1'b0;
        end else begin
            if (mem_ctl.rd) begin
                r_x <= r_x + XW'(1);
            end
            if (r_rd_vld && ((mem_rdata & r_mask) != '0)) begin
                r_hit <= 1'b1;
            end
        end
        if (mem_ctl.rd) begin
            r_rd_x <= r_x[XA-1:0];
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_free <= (r_op == ogbmc_pkg::OP_CHECK) && !r_outside && !r_hit;
            r_out_oob  <= r_oob;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'b0, r_out_oob, r_out_free};

    // a row is never read and written back in the same cycle
    a_no_same_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_ctl.rd && mem_ctl.wr) |-> (r_x[XA-1:0] != r_rd_x))
        else $error("row read and write collide");

    // rows are written only while a mark walks its box
    a_wr_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.wr |-> ((r_state == S_WALK) && (r_op == ogbmc_pkg::OP_MARK)))
        else $error("row write outside a mark walk");

    // a free box is never reported out of bounds
    a_free_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("free and out of bounds together");

    // one request at a time: no acceptance right after an acceptance
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("request taken while busy");

endmodule
